@@ src/assert_macros.svh @@
// Assertion macros for the RTL, included by websocket_frame_deframer.sv.
// Needs a clock named i_clk and an active-low reset named i_rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Immediate-cycle implication, checked at every rising edge out of reset.
`define ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/wsfd_pkg.sv @@
// Package for the websocket frame deframer: item types, parser phases, constants.
// No dependencies.
`default_nettype none

package wsfd_pkg;

    // Width kept for the decoded payload length and the payload counter.
    localparam int LENGTH_BITS = 64;
    localparam int OUT_LEN_W   = 64;

    localparam logic [7:0] MASK_BIT   = 8'h80;
    localparam logic [6:0] LEN7_EXT16 = 7'd126;
    localparam logic [6:0] LEN7_EXT64 = 7'd127;
    localparam logic [3:0] EXT_CNT_16 = 4'd2;
    localparam logic [3:0] EXT_CNT_64 = 4'd8;
    localparam logic [2:0] KEY_BYTES  = 3'd4;

    localparam logic ACT_FEED  = 1'b0;
    localparam logic ACT_START = 1'b1;

    typedef enum logic [2:0] {
        PH_IDLE    = 3'd0,
        PH_BYTE0   = 3'd1,
        PH_BYTE1   = 3'd2,
        PH_EXTLEN  = 3'd3,
        PH_KEY     = 3'd4,
        PH_PAYLOAD = 3'd5,
        PH_DONE    = 3'd6
    } t_phase;

    typedef struct packed {
        logic       action;
        logic [7:0] in_byte;
    } t_in_item;

    typedef struct packed {
        logic                 accepted;
        logic                 header_valid;
        logic                 fin;
        logic                 rsv1;
        logic                 rsv2;
        logic                 rsv3;
        logic [3:0]           opcode;
        logic                 masked;
        logic [OUT_LEN_W-1:0] payload_length;
        logic                 payload_valid;
        logic [7:0]           payload_byte;
        logic                 frame_done;
    } t_out_item;

endpackage

`default_nettype wire

@@ src/wsfd_parser.sv @@
// Frame parser state and per-byte update logic (one byte per transfer).
// Depends on wsfd_pkg.
`default_nettype none

module wsfd_parser (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_step,
    input  wire wsfd_pkg::t_in_item  i_item,
    output wsfd_pkg::t_out_item      o_result
);
    import wsfd_pkg::*;

    t_phase                 r_phase,  n_phase;
    logic [7:0]             r_header, n_header;
    logic                   r_mask,   n_mask;
    logic [LENGTH_BITS-1:0] r_length, n_length;
    logic                   r_ext_long, n_ext_long;
    logic [3:0]             r_ext_cnt, n_ext_cnt;
    logic [31:0]            r_key,    n_key;
    logic [2:0]             r_key_cnt, n_key_cnt;
    logic [LENGTH_BITS-1:0] r_pay_cnt, n_pay_cnt;

    logic [7:0] b;
    logic       len_ext;       // second byte selects an extended length
    logic       ext_last;      // last extended length byte
    logic       key_last;      // last key byte
    logic       pay_last;      // last payload byte
    logic       len_zero;      // updated length is zero
    logic [7:0] key_byte;

    assign b        = i_item.in_byte;
    assign len_ext  = (b[6:0] == LEN7_EXT16) || (b[6:0] == LEN7_EXT64);
    assign len_zero = (n_length == '0);
    assign ext_last = (n_ext_cnt >= (r_ext_long ? EXT_CNT_64 : EXT_CNT_16));
    assign key_last = (n_key_cnt >= KEY_BYTES);
    assign pay_last = (n_pay_cnt >= r_length);

    always_comb begin
        unique case (r_pay_cnt[1:0])
            2'd0:    key_byte = r_key[31:24];
            2'd1:    key_byte = r_key[23:16];
            2'd2:    key_byte = r_key[15:8];
            default: key_byte = r_key[7:0];
        endcase
    end

    // Datapath next values for a fed byte.
    always_comb begin
        n_header   = r_header;
        n_mask     = r_mask;
        n_length   = r_length;
        n_ext_long = r_ext_long;
        n_ext_cnt  = r_ext_cnt;
        n_key      = r_key;
        n_key_cnt  = r_key_cnt;
        n_pay_cnt  = r_pay_cnt;
        unique case (r_phase)
            PH_BYTE0: begin
                n_header = b;
            end
            PH_BYTE1: begin
                n_mask    = ((b & MASK_BIT) != 8'h00);
                n_pay_cnt = '0;
                n_ext_cnt = '0;
                if (len_ext) begin
                    n_ext_long = (b[6:0] == LEN7_EXT64);
                    n_length   = '0;
                end else begin
                    n_length = LENGTH_BITS'(b[6:0]);
                end
            end
            PH_EXTLEN: begin
                // saturate once set bits would leave the kept width
                if (r_length[LENGTH_BITS-1 -: 8] != 8'h00) begin
                    n_length = '1;
                end else begin
                    n_length = {r_length[LENGTH_BITS-9:0], b};
                end
                n_ext_cnt = r_ext_cnt + 4'd1;
            end
            PH_KEY: begin
                n_key     = {r_key[23:0], b};
                n_key_cnt = r_key_cnt + 3'd1;
            end
            PH_PAYLOAD: begin
                n_pay_cnt = r_pay_cnt + LENGTH_BITS'(1);
            end
            default: begin
            end
        endcase
    end

    // Next phase for a fed byte.
    always_comb begin
        n_phase = r_phase;
        unique case (r_phase)
            PH_BYTE0: n_phase = PH_BYTE1;
            PH_BYTE1: begin
                if (len_ext)       n_phase = PH_EXTLEN;
                else if (n_mask)   n_phase = PH_KEY;
                else if (!len_zero) n_phase = PH_PAYLOAD;
                else               n_phase = PH_DONE;
            end
            PH_EXTLEN: begin
                if (ext_last) begin
                    if (r_mask)         n_phase = PH_KEY;
                    else if (!len_zero) n_phase = PH_PAYLOAD;
                    else                n_phase = PH_DONE;
                end
            end
            PH_KEY: begin
                if (key_last) n_phase = len_zero ? PH_DONE : PH_PAYLOAD;
            end
            PH_PAYLOAD: begin
                if (pay_last) n_phase = PH_DONE;
            end
            default: n_phase = r_phase;
        endcase
    end

    // Result fields for a fed byte.
    always_comb begin
        o_result                = '0;
        o_result.fin            = n_header[7];
        o_result.rsv1           = n_header[6];
        o_result.rsv2           = n_header[5];
        o_result.rsv3           = n_header[4];
        o_result.opcode         = n_header[3:0];
        o_result.masked         = n_mask;
        o_result.payload_length = OUT_LEN_W'(n_length);
        unique case (r_phase)
            PH_BYTE0: o_result.accepted = 1'b1;
            PH_BYTE1: begin
                o_result.accepted     = 1'b1;
                o_result.header_valid = !len_ext;
                o_result.frame_done   = !len_ext && !n_mask && len_zero;
            end
            PH_EXTLEN: begin
                o_result.accepted     = 1'b1;
                o_result.header_valid = ext_last;
                o_result.frame_done   = ext_last && !r_mask && len_zero;
            end
            PH_KEY: begin
                o_result.accepted   = 1'b1;
                o_result.frame_done = key_last && len_zero;
            end
            PH_PAYLOAD: begin
                o_result.accepted      = 1'b1;
                o_result.payload_valid = 1'b1;
                o_result.payload_byte  = r_mask ? (b ^ key_byte) : b;
                o_result.frame_done    = pay_last;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_IDLE;
            r_header   <= '0;
            r_mask     <= 1'b0;
            r_length   <= '0;
            r_ext_long <= 1'b0;
            r_ext_cnt  <= '0;
            r_key      <= '0;
            r_key_cnt  <= '0;
            r_pay_cnt  <= '0;
        end else if (i_step) begin
            if (i_item.action == ACT_START) begin
                r_phase    <= PH_BYTE0;
                r_header   <= '0;
                r_mask     <= 1'b0;
                r_length   <= '0;
                r_ext_long <= 1'b0;
                r_ext_cnt  <= '0;
                r_key      <= '0;
                r_key_cnt  <= '0;
                r_pay_cnt  <= '0;
            end else begin
                r_phase    <= n_phase;
                r_header   <= n_header;
                r_mask     <= n_mask;
                r_length   <= n_length;
                r_ext_long <= n_ext_long;
                r_ext_cnt  <= n_ext_cnt;
                r_key      <= n_key;
                r_key_cnt  <= n_key_cnt;
                r_pay_cnt  <= n_pay_cnt;
            end
        end
    end

endmodule

`default_nettype wire

@@ src/websocket_frame_deframer.sv @@
// Top level of the websocket frame deframer: handshakes and result register.
// Depends on wsfd_pkg, wsfd_parser and assert_macros.svh.
//
// Usage:
//   Input channel (i_valid / i_item, o_stall): one transfer per stream byte.
//   action = start arms the parser and clears all frame state; it yields no
//   result. action = feed presents one stream byte and always yields exactly
//   one result, with accepted = 0 when no frame is armed or the frame is done.
//   Output channel (o_valid / o_result, i_stall): one result per feed.
//   The result is registered in the output register in the cycle after its byte
//   is taken. Throughput: one byte per cycle while the output is not stalled;
//   the parser state update is a single registered step (the widest path is
//   the 64-bit payload count add and compare against the decoded length).
//   Stall: while the receiver stalls a full result register, o_stall rises
//   and no input is taken; the result register and parser state hold. A
//   result taken in the same cycle frees the register for the next byte.
//   Reset (i_rst_n low, synchronous): the parser is unarmed, all header,
//   length, key and count state is zero, and the result register is empty.
`default_nettype none

module websocket_frame_deframer (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_stall,
    input  wire wsfd_pkg::t_in_item i_item,
    output logic                    o_valid,
    input  wire logic               i_stall,
    output wsfd_pkg::t_out_item     o_result
);
    import wsfd_pkg::*;

    logic      in_xfer;     // input transfer this cycle
    logic      out_xfer;    // output transfer this cycle
    logic      feed_xfer;   // input transfer that produces a result
    t_out_item step_res;
    logic      r_out_valid;
    t_out_item r_out;

    // Output register can take a new result when empty or draining now.
    assign o_stall   = r_out_valid && i_stall;
    assign in_xfer   = i_valid && !o_stall;
    assign out_xfer  = r_out_valid && !i_stall;
    assign feed_xfer = in_xfer && (i_item.action == ACT_FEED);

    wsfd_parser u_parser (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (in_xfer),
        .i_item   (i_item),
        .o_result (step_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (feed_xfer) begin
            r_out_valid <= 1'b1;
        end else if (out_xfer) begin
            r_out_valid <= 1'b0;
        end
    end

    // Payload register: no reset needed.
    always_ff @(posedge i_clk) begin
        if (feed_xfer) begin
            r_out <= step_res;
        end
    end

    assign o_valid  = r_out_valid;
    assign o_result = r_out;

`include "assert_macros.svh"

    `ASSERT_NEXT(a_feed_gives_result, feed_xfer, r_out_valid, "fed byte produced no result")
    `ASSERT_IMPL(a_stall_only_full, o_stall, r_out_valid, "input stalled with empty output")
    `ASSERT_IMPL(a_payload_accepted, r_out_valid && r_out.payload_valid, r_out.accepted, "payload byte not accepted")
    `ASSERT_IMPL(a_done_accepted, r_out_valid && r_out.frame_done, r_out.accepted, "frame done on rejected byte")

endmodule

`default_nettype wire
